@@ sv/assert_macros.svh @@
// assertion helpers used by the top-level rtl file
// each expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SGF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SGF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sgf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgf_pkg
// Shared widths, codes and control structs of the sample gap filler.
// ---------------------------------------------------------------------------
package sgf_pkg;

	localparam int FRAME_LEN_DEF = 128;
	localparam int MAX_GAP       = 63;

	localparam int VAL_W  = 8;
	localparam int GAP_W  = 6;
	localparam int SUM_W  = 15;
	localparam int AVG_W  = 12;
	localparam int KIND_W = 2;

	// kind of each cleaned sample
	typedef enum logic [KIND_W-1:0] {
		FK_ORIG   = 2'd0,
		FK_INTERP = 2'd1,
		FK_HOLD   = 2'd2,
		FK_ZERO   = 2'd3
	} fill_kind_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_MUL,
		ST_FINISH
	} sgf_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
		logic load;
		logic mul;
		logic finish;
	} sgf_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic emit_needed;
		logic gap_zero;
		logic frame_last;
		logic out_free;
	} sgf_status_t;

endpackage

@@ sv/sgf_in_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgf_in_if
// Sample channel: one sample with its missing mark per beat.
// ---------------------------------------------------------------------------
interface sgf_in_if import sgf_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] sample_value;
	logic             sample_missing;

	modport source (output valid, output sample_value, output sample_missing, input ready);
	modport sink (input valid, input sample_value, input sample_missing, output ready);
endinterface

@@ sv/sgf_out_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgf_out_if
// Result channel: one cleaned sample per beat, frame statistics at frame end.
// ---------------------------------------------------------------------------
interface sgf_out_if import sgf_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  clean_value;
	logic [KIND_W-1:0] fill_kind;
	logic              run_last;
	logic              frame_end;
	logic [VAL_W-1:0]  frame_min;
	logic [VAL_W-1:0]  frame_max;
	logic [AVG_W-1:0]  frame_average;
	logic              gap_overflow;

	modport source (
		output valid, output clean_value, output fill_kind, output run_last,
		output frame_end, output frame_min, output frame_max, output frame_average,
		output gap_overflow, input ready
	);
	modport sink (
		input valid, input clean_value, input fill_kind, input run_last,
		input frame_end, input frame_min, input frame_max, input frame_average,
		input gap_overflow, output ready
	);
endinterface

@@ sv/sgf_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgf_ctrl
// Controller: takes samples, steps through the results of each sample and
// runs the average multiply at the end of a frame.
// ---------------------------------------------------------------------------
module sgf_ctrl import sgf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sgf_status_t status,
	output sgf_cmd_t    cmd
);

	sgf_state_t state_q;
	sgf_state_t state_d;
	logic       closing_final;

	assign closing_final = status.gap_zero && status.frame_last;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.emit_needed) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (closing_final) begin
					state_d = ST_MUL;
				end else if (status.out_free && status.gap_zero) begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_EMIT: begin
				// the frame's final result waits for its statistics
				if (closing_final) begin
					cmd.step = 1'b1;
				end else if (status.out_free) begin
					cmd.step = 1'b1;
					cmd.load = 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_FINISH: begin
				cmd.finish = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ sv/sgf_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgf_dp
// Datapath: frame state, gap fill arithmetic, running statistics, average
// by reciprocal multiply and the result register.
// ---------------------------------------------------------------------------
module sgf_dp import sgf_pkg::*; #(
	parameter int FRAME_LEN = FRAME_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sgf_cmd_t          cmd,
	output sgf_status_t       status,
	input  logic [VAL_W-1:0]  sample_value,
	input  logic              sample_missing,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [VAL_W-1:0]  clean_value,
	output logic [KIND_W-1:0] fill_kind,
	output logic              run_last,
	output logic              frame_end,
	output logic [VAL_W-1:0]  frame_min,
	output logic [VAL_W-1:0]  frame_max,
	output logic [AVG_W-1:0]  frame_average,
	output logic              gap_overflow
);

	localparam int POS_W   = $clog2(FRAME_LEN);
	// sum*16 divided by the frame length: exact reciprocal for all dividends
	localparam int DIVD_W  = SUM_W + 4;
	localparam int RECIP_W = DIVD_W + 1;
	localparam int SHIFT   = DIVD_W + $clog2(FRAME_LEN);
	localparam int PROD_W  = DIVD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) / 64'(FRAME_LEN)) + 64'd1);

	// current sample
	logic [VAL_W-1:0]  value_q;
	logic              missing_q;
	logic              last_q;
	// frame state
	logic [VAL_W-1:0]  left_q;
	logic              have_left_q;
	logic [GAP_W-1:0]  gap_q;
	logic [POS_W-1:0]  pos_q;
	logic [VAL_W-1:0]  min_q;
	logic [VAL_W-1:0]  max_q;
	logic [SUM_W-1:0]  sum_q;
	logic              ovf_q;
	logic [PROD_W-1:0] prod_s1;
	logic              out_valid_q;

	logic              last_now;
	logic              ovf_now;
	logic              gap_zero;
	logic [VAL_W-1:0]  interp;
	logic [VAL_W-1:0]  hold_val;
	fill_kind_t        hold_kind;
	logic [VAL_W-1:0]  res_val;
	fill_kind_t        res_kind;
	logic              res_ovf;

	// decision for an incoming sample
	assign last_now = pos_q >= POS_W'(FRAME_LEN - 1);
	assign ovf_now  = ovf_q || (gap_q >= GAP_W'(MAX_GAP));
	assign gap_zero = gap_q == '0;

	assign status.emit_needed = !sample_missing || last_now || ovf_now;
	assign status.gap_zero    = gap_zero;
	assign status.frame_last  = last_q;
	assign status.out_free    = !out_valid_q || out_ready;

	// result being produced now
	assign interp    = VAL_W'((({1'b0, left_q}) + ({1'b0, value_q})) >> 1);
	assign hold_val  = have_left_q ? left_q : '0;
	assign hold_kind = have_left_q ? FK_HOLD : FK_ZERO;

	always_comb begin
		if (missing_q) begin
			res_val  = hold_val;
			res_kind = hold_kind;
			res_ovf  = ovf_q;
		end else if (!gap_zero) begin
			res_val  = have_left_q ? interp : value_q;
			res_kind = have_left_q ? FK_INTERP : FK_HOLD;
			res_ovf  = 1'b0;
		end else begin
			res_val  = value_q;
			res_kind = FK_ORIG;
			res_ovf  = 1'b0;
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			value_q   <= sample_value;
			missing_q <= sample_missing;
			last_q    <= last_now;
		end
	end

	// frame state and running statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			have_left_q <= 1'b0;
			gap_q       <= '0;
			pos_q       <= '0;
			min_q       <= '1;
			max_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
		end else if (cmd.finish) begin
			left_q      <= '0;
			have_left_q <= 1'b0;
			gap_q       <= '0;
			pos_q       <= '0;
			min_q       <= '1;
			max_q       <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
		end else if (cmd.accept) begin
			if (!last_now) begin
				pos_q <= pos_q + 1'b1;
			end
			if (sample_missing) begin
				if (last_now || ovf_now) begin
					ovf_q <= ovf_now;
				end else begin
					gap_q <= gap_q + 1'b1;
				end
			end else begin
				ovf_q <= 1'b0;
			end
		end else if (cmd.step) begin
			if (res_val < min_q) begin
				min_q <= res_val;
			end
			if (res_val > max_q) begin
				max_q <= res_val;
			end
			sum_q <= sum_q + SUM_W'(res_val);
			if (!gap_zero) begin
				gap_q <= gap_q - 1'b1;
				if (!missing_q && have_left_q) begin
					left_q <= interp;
				end
			end else if (!missing_q) begin
				left_q      <= value_q;
				have_left_q <= 1'b1;
			end
		end
	end

	// average multiply
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= PROD_W'({sum_q, 4'b0000}) * PROD_W'(RECIP);
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.load || cmd.finish) begin
			clean_value  <= res_val;
			fill_kind    <= KIND_W'(res_kind);
			gap_overflow <= res_ovf;
			run_last     <= gap_zero;
			frame_end    <= cmd.finish;
			if (cmd.finish) begin
				frame_min     <= min_q;
				frame_max     <= max_q;
				frame_average <= prod_s1[SHIFT +: AVG_W];
			end else begin
				frame_min     <= '0;
				frame_max     <= '0;
				frame_average <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/sample_gap_filler_with_stats.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sample_gap_filler_with_stats
// Fills missing samples from their neighbors and reports per-frame min, max
// and average of the cleaned samples.
// ---------------------------------------------------------------------------
// Samples come in frames of FRAME_LEN beats. A missing sample produces no
// result until its gap closes; the closing sample then releases the filled
// samples in order followed by itself, one result beat per cycle while the
// output is not stalled, from a single output register. No new sample is
// taken until a sample has released all its results; a missing sample
// inside a gap releases none and is only taken. For the frame's last
// sample the average is formed first, by a reciprocal multiply of the
// frame sum followed by a register. Gaps over 63 samples are flushed at
// the hold value with gap_overflow set.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sample_gap_filler_with_stats import sgf_pkg::*; #(
	parameter int FRAME_LEN = FRAME_LEN_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sgf_in_if.sink    samples,
	sgf_out_if.source results
);

	sgf_cmd_t    cmd;
	sgf_status_t status;

	// controller
	sgf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	sgf_dp #(
		.FRAME_LEN (FRAME_LEN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.sample_value   (samples.sample_value),
		.sample_missing (samples.sample_missing),
		.out_valid      (results.valid),
		.out_ready      (results.ready),
		.clean_value    (results.clean_value),
		.fill_kind      (results.fill_kind),
		.run_last       (results.run_last),
		.frame_end      (results.frame_end),
		.frame_min      (results.frame_min),
		.frame_max      (results.frame_max),
		.frame_average  (results.frame_average),
		.gap_overflow   (results.gap_overflow)
	);

	// checks
	`SGF_ASSERT_IMP(a_end_is_run_last, results.valid && results.frame_end, results.run_last, "frame end beat is not the last of its run")
	`SGF_ASSERT_IMP(a_orig_no_ovf, results.valid && (results.fill_kind == FK_ORIG), !results.gap_overflow, "original sample flagged as gap overflow")
	`SGF_ASSERT_IMP(a_stats_only_at_end, results.valid && !results.frame_end, (results.frame_min == '0) && (results.frame_max == '0) && (results.frame_average == '0), "statistics present before frame end")
	`SGF_ASSERT_NXT(a_mul_then_idle_dp, cmd.mul, !cmd.step && !cmd.accept, "datapath stepped during average")

endmodule
